// ===== rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, register indexes and reset values shared by the PID controller
// with feedforward and integral clamp.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INT_GAIN_DT  = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_FF_GAIN      = 3'd3,
    REG_ACCUM_LIMIT  = 3'd4,
    REG_OUT_LOW      = 3'd5,
    REG_OUT_HIGH     = 3'd6
  } cfg_reg_t;

  localparam logic signed [15:0] OUT_LOW_RST  = -16'sd127;
  localparam logic signed [15:0] OUT_HIGH_RST = 16'sd127;

  typedef struct packed {
    logic signed [31:0] measured;
    logic signed [31:0] setpoint;
    logic signed [31:0] feedforward_in;
  } pfc_in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [31:0] pid_sum;
  } pfc_out_t;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] int_gain_dt;
    logic signed [31:0] deriv_gain_per_dt;
    logic signed [31:0] ff_gain;
    logic        [30:0] accum_limit;
    logic signed [15:0] out_low;
    logic signed [15:0] out_high;
  } pfc_cfg_t;

  // Terms handed from the error stage to the multiplier stage.
  typedef struct packed {
    logic signed [31:0] err;
    logic signed [31:0] acc;
    logic signed [32:0] diff;
    logic signed [31:0] ff;
  } pfc_terms_t;

  // Full-precision products: Q32.32, and Q33.32 for the derivative term.
  typedef struct packed {
    logic signed [63:0] p_ff;
    logic signed [63:0] p_prop;
    logic signed [63:0] p_int;
    logic signed [64:0] p_deriv;
  } pfc_prod_t;

endpackage

// ===== rtl/pfc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pfc_cfg_regs
// Configuration register file: gains, accumulator bound and drive range.
// ----------------------------------------------------------------------------
module pfc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pfc_pkg::CfgDataW-1:0]  cfg_data,
  output pfc_pkg::pfc_cfg_t             cfg
);

  pfc_pkg::pfc_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain         <= '0;
      cfg_r.int_gain_dt       <= '0;
      cfg_r.deriv_gain_per_dt <= '0;
      cfg_r.ff_gain           <= '0;
      cfg_r.accum_limit       <= '0;
      cfg_r.out_low           <= pfc_pkg::OUT_LOW_RST;
      cfg_r.out_high          <= pfc_pkg::OUT_HIGH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfc_pkg::REG_PROP_GAIN:   cfg_r.prop_gain         <= $signed(cfg_data);
        pfc_pkg::REG_INT_GAIN_DT: cfg_r.int_gain_dt       <= $signed(cfg_data);
        pfc_pkg::REG_DERIV_GAIN:  cfg_r.deriv_gain_per_dt <= $signed(cfg_data);
        pfc_pkg::REG_FF_GAIN:     cfg_r.ff_gain           <= $signed(cfg_data);
        pfc_pkg::REG_ACCUM_LIMIT: cfg_r.accum_limit       <= cfg_data[30:0];
        pfc_pkg::REG_OUT_LOW:     cfg_r.out_low           <= $signed(cfg_data[15:0]);
        pfc_pkg::REG_OUT_HIGH:    cfg_r.out_high          <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pfc_err_stage.sv =====
// ----------------------------------------------------------------------------
// pfc_err_stage
// Input register, then saturated error, clamped integrator and error
// difference. The integrator and previous error update as an item moves on.
// ----------------------------------------------------------------------------
module pfc_err_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfc_pkg::pfc_cfg_t     cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pfc_pkg::pfc_in_t      in_data,
  output logic                  terms_valid,
  input  logic                  terms_ready,
  output pfc_pkg::pfc_terms_t   terms
);

  logic                v0_r;
  pfc_pkg::pfc_in_t    d0_r;
  logic                v1_r;
  pfc_pkg::pfc_terms_t s1_r;
  pfc_pkg::pfc_terms_t s1_nxt;
  logic signed [31:0]  accum_r;
  logic signed [31:0]  last_err_r;

  logic                s1_free;
  logic                s0_free;
  logic signed [32:0]  raw_err;
  logic signed [31:0]  err;
  logic signed [32:0]  acc_sum;
  logic signed [32:0]  lim_pos;
  logic signed [32:0]  lim_neg;
  logic signed [32:0]  acc_clamped;

  assign s1_free     = !v1_r || terms_ready;
  assign s0_free     = !v0_r || s1_free;
  assign in_ready    = s0_free;
  assign terms_valid = v1_r;
  assign terms       = s1_r;

  always_comb begin
    raw_err = $signed({d0_r.setpoint[31], d0_r.setpoint})
            - $signed({d0_r.measured[31], d0_r.measured});
    if (raw_err[32] != raw_err[31]) begin
      err = raw_err[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err = raw_err[31:0];
    end

    acc_sum = $signed({accum_r[31], accum_r}) + $signed({err[31], err});
    lim_pos = $signed({2'b00, cfg.accum_limit});
    lim_neg = -lim_pos;
    if (acc_sum > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc_sum < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc_sum;
    end

    s1_nxt.err  = err;
    s1_nxt.acc  = acc_clamped[31:0];
    s1_nxt.diff = $signed({err[31], err}) - $signed({last_err_r[31], last_err_r});
    s1_nxt.ff   = d0_r.feedforward_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
      accum_r    <= '0;
      last_err_r <= '0;
    end else begin
      if (s0_free) begin
        v0_r <= in_valid;
      end
      if (s1_free) begin
        v1_r <= v0_r;
        if (v0_r) begin
          accum_r    <= s1_nxt.acc;
          last_err_r <= s1_nxt.err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_free && in_valid) begin
      d0_r <= in_data;
    end
    if (s1_free && v0_r) begin
      s1_r <= s1_nxt;
    end
  end

  // The integrator never leaves the bound once a step has been taken.
  a_accum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_free && v0_r) |=>
      (accum_r <= $signed({1'b0, cfg.accum_limit}) &&
       accum_r >= -$signed({1'b0, cfg.accum_limit})))
    else $error("integrator outside its bound after a step");

  a_last_err: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_free && v0_r) |=> (last_err_r == s1_r.err && accum_r == s1_r.acc))
    else $error("controller state does not match the forwarded terms");

endmodule

// ===== rtl/pfc_mult_stage.sv =====
// ----------------------------------------------------------------------------
// pfc_mult_stage
// Four signed multipliers in parallel, products registered at full width.
// ----------------------------------------------------------------------------
module pfc_mult_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfc_pkg::pfc_cfg_t     cfg,
  input  logic                  terms_valid,
  output logic                  terms_ready,
  input  pfc_pkg::pfc_terms_t   terms,
  output logic                  prod_valid,
  input  logic                  prod_ready,
  output pfc_pkg::pfc_prod_t    prod
);

  logic               v2_r;
  pfc_pkg::pfc_prod_t prod_r;
  pfc_pkg::pfc_prod_t prod_nxt;
  logic               s2_free;

  assign s2_free     = !v2_r || prod_ready;
  assign terms_ready = s2_free;
  assign prod_valid  = v2_r;
  assign prod        = prod_r;

  always_comb begin
    prod_nxt.p_ff    = $signed(cfg.ff_gain) * $signed(terms.ff);
    prod_nxt.p_prop  = $signed(cfg.prop_gain) * $signed(terms.err);
    prod_nxt.p_int   = $signed(cfg.int_gain_dt) * $signed(terms.acc);
    prod_nxt.p_deriv = $signed(cfg.deriv_gain_per_dt) * $signed(terms.diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_free) begin
      v2_r <= terms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && terms_valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== rtl/pfc_sum_stage.sv =====
// ----------------------------------------------------------------------------
// pfc_sum_stage
// Exact sum of the products, floor to Q16.16 and to integer, saturation,
// drive clamp and the result register.
// ----------------------------------------------------------------------------
module pfc_sum_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfc_pkg::pfc_cfg_t     cfg,
  input  logic                  prod_valid,
  output logic                  prod_ready,
  input  pfc_pkg::pfc_prod_t    prod,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pfc_pkg::pfc_out_t     out_data
);

  logic               v3_r;
  pfc_pkg::pfc_out_t  out_r;
  pfc_pkg::pfc_out_t  out_nxt;
  logic               s3_free;
  logic signed [66:0] total;
  logic signed [50:0] q16;
  logic signed [34:0] drv;
  logic signed [34:0] hi_ext;
  logic signed [34:0] lo_ext;

  assign s3_free    = !v3_r || out_ready;
  assign prod_ready = s3_free;
  assign out_valid  = v3_r;
  assign out_data   = out_r;

  always_comb begin
    total = $signed({{3{prod.p_ff[63]}}, prod.p_ff})
          + $signed({{3{prod.p_prop[63]}}, prod.p_prop})
          + $signed({{3{prod.p_int[63]}}, prod.p_int})
          + $signed({{2{prod.p_deriv[64]}}, prod.p_deriv});
    // Dropping low bits of a two's complement value floors it.
    q16    = total[66:16];
    drv    = total[66:32];
    hi_ext = $signed({{19{cfg.out_high[15]}}, cfg.out_high});
    lo_ext = $signed({{19{cfg.out_low[15]}}, cfg.out_low});

    // The high test comes first so an inverted range still resolves.
    if (drv > hi_ext) begin
      out_nxt.drive = cfg.out_high;
    end else if (drv < lo_ext) begin
      out_nxt.drive = cfg.out_low;
    end else begin
      out_nxt.drive = drv[15:0];
    end

    if (q16[50:31] != {20{q16[50]}}) begin
      out_nxt.pid_sum = q16[50] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      out_nxt.pid_sum = q16[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (s3_free) begin
      v3_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && prod_valid) begin
      out_r <= out_nxt;
    end
  end

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && cfg.out_low <= cfg.out_high) |->
      (out_r.drive >= cfg.out_low && out_r.drive <= cfg.out_high))
    else $error("drive outside the configured range");

endmodule

// ===== rtl/pid_feedforward_controller_core.sv =====
// ----------------------------------------------------------------------------
// pid_feedforward_controller_core
// PID controller with feedforward and clamped integrator, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Stages: input register, error/integrator register, product register and
//   result register. Throughput: one item per cycle unless out_ready stalls;
//   the integrator updates as each item moves into the error register.
// Reset: synchronous active-low rst_n clears all valids, the integrator and
//   the previous error; registers return to their reset values.
module pid_feedforward_controller_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pfc_pkg::pfc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pfc_pkg::pfc_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pfc_pkg::CfgDataW-1:0]  cfg_data
);

  pfc_pkg::pfc_cfg_t   cfg;
  pfc_pkg::pfc_terms_t terms;
  pfc_pkg::pfc_prod_t  prod;
  logic                terms_valid;
  logic                terms_ready;
  logic                prod_valid;
  logic                prod_ready;

  pfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfc_err_stage u_err (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms)
  );

  pfc_mult_stage u_mult (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms),
    .prod_valid  (prod_valid),
    .prod_ready  (prod_ready),
    .prod        (prod)
  );

  pfc_sum_stage u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point PID controller with feedforward and
// clamped integrator. A directed part covers error saturation, the wide
// derivative difference, the integrator clamp, the feedforward term, the drive
// range and an unused register index. Random phases with fresh gains and
// limits follow, along with output back-pressure and a full sender pause. The
// bench predicts every result from its own model of the controller state.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pfc_pkg::CfgIdxW-1:0] REG_SPARE = 3'd7;  // not decoded by the block
  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] I32_MIN = 32'h8000_0000;
  localparam logic signed [79:0] SAT_HI = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] SAT_LO = -80'sh8000_0000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 3000;
  localparam int REPORT_MAX     = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  pfc_pkg::pfc_in_t   in_data;
  logic               out_valid;
  logic               out_ready;
  pfc_pkg::pfc_out_t  out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [pfc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [pfc_pkg::CfgDataW-1:0] cfg_data;

  // Controller image kept by the bench.
  logic signed [31:0] kp = '0, ki = '0, kd = '0, kf = '0;
  logic        [30:0] acc_lim = '0;
  logic signed [15:0] drv_lo = pfc_pkg::OUT_LOW_RST;
  logic signed [15:0] drv_hi = pfc_pkg::OUT_HIGH_RST;
  logic signed [31:0] integ_acc = '0;
  logic signed [31:0] prev_err = '0;

  pfc_pkg::pfc_out_t ctrl_expect_q[$];
  int       n_fail = 0;
  bit       idle_on = 1'b1;
  bit       rx_hold_req = 1'b0;
  int       stall_cycles = 0;

  pid_feedforward_controller_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One control tick: updates the integrator and previous error, returns the result.
  function automatic pfc_pkg::pfc_out_t compute_control(input pfc_pkg::pfc_in_t item);
    logic signed [79:0] meas, sp, ff, err, acc, diff, lim, sum, q16, drv;
    pfc_pkg::pfc_out_t res;
    meas = $signed(item.measured);
    sp   = $signed(item.setpoint);
    ff   = $signed(item.feedforward_in);
    err  = sp - meas;
    if (err > SAT_HI) err = SAT_HI;
    else if (err < SAT_LO) err = SAT_LO;
    lim = $signed({49'd0, acc_lim});
    acc = err + integ_acc;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    diff = err - prev_err;
    integ_acc = acc[31:0];
    prev_err  = err[31:0];
    sum = ff * kf + err * kp + acc * ki + diff * kd;
    q16 = sum >>> 16;
    drv = q16 >>> 16;
    // The high bound is tested first, which matters when the range is inverted.
    if (drv > drv_hi) drv = drv_hi;
    else if (drv < drv_lo) drv = drv_lo;
    res.drive = drv[15:0];
    if (q16 > SAT_HI) q16 = SAT_HI;
    else if (q16 < SAT_LO) q16 = SAT_LO;
    res.pid_sum = q16[31:0];
    return res;
  endfunction

  function automatic pfc_pkg::pfc_in_t make_item(input logic [31:0] m, s, f);
    pfc_pkg::pfc_in_t r;
    r.measured       = m;
    r.setpoint       = s;
    r.feedforward_in = f;
    return r;
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return I32_MIN;
      2: return I32_MAX;
      3: return 32'h0;
      default: return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return I32_MIN;
      2: return I32_MAX;
      3: return 32'h0;
      default: return $urandom_range(0, 32'h10_0000) - 32'h8_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return {1'($urandom()), 31'($urandom_range(0, 32'h4_0000))};
    endcase
  endfunction

  // Mostly a setpoint that tracks the measurement closely, as in a running loop.
  function automatic pfc_pkg::pfc_in_t random_item();
    logic [31:0] m, s;
    m = pick_level();
    if ($urandom_range(0, 3) != 0) s = m + $urandom_range(0, 32'h6_0000) - 32'h3_0000;
    else s = pick_level();
    return make_item(m, s, pick_level());
  endfunction

  task automatic send_item(input pfc_pkg::pfc_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    ctrl_expect_q.push_back(compute_control(item));
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    while (ctrl_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pfc_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pfc_pkg::REG_PROP_GAIN:   kp = data;
      pfc_pkg::REG_INT_GAIN_DT: ki = data;
      pfc_pkg::REG_DERIV_GAIN:  kd = data;
      pfc_pkg::REG_FF_GAIN:     kf = data;
      pfc_pkg::REG_ACCUM_LIMIT: acc_lim = data[30:0];
      pfc_pkg::REG_OUT_LOW:     drv_lo = data[15:0];
      pfc_pkg::REG_OUT_HIGH:    drv_hi = data[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_random();
    logic [15:0] lo, hi;
    write_reg(pfc_pkg::REG_PROP_GAIN, pick_gain());
    write_reg(pfc_pkg::REG_INT_GAIN_DT, pick_gain());
    write_reg(pfc_pkg::REG_DERIV_GAIN, pick_gain());
    write_reg(pfc_pkg::REG_FF_GAIN, pick_gain());
    write_reg(pfc_pkg::REG_ACCUM_LIMIT, pick_limit());
    case ($urandom_range(0, 4))
      0: begin
        lo = 16'h8000;
        hi = 16'h7FFF;
      end
      1: begin
        lo = 16'($urandom());
        hi = 16'($urandom());
      end
      2: begin
        lo = 16'($urandom_range(1, 300));
        hi = 16'h0 - 16'($urandom_range(1, 300));
      end
      default: begin
        lo = 16'h0 - 16'($urandom_range(1, 300));
        hi = 16'($urandom_range(1, 300));
      end
    endcase
    write_reg(pfc_pkg::REG_OUT_LOW, {16'($urandom()), lo});
    write_reg(pfc_pkg::REG_OUT_HIGH, {16'($urandom()), hi});
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, $urandom());
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    settle();
    send_item(make_item(I32_MIN, I32_MAX, I32_MAX));
    send_item(make_item(I32_MAX, I32_MIN, I32_MIN));
  endtask

  task automatic test_error_saturation();
    settle();
    write_reg(pfc_pkg::REG_PROP_GAIN, Q_ONE);
    send_item(make_item(I32_MIN, I32_MAX, 32'h0));
    send_item(make_item(I32_MAX, I32_MIN, 32'h0));
  endtask

  // Swinging from one saturated error to the other needs the full 33-bit difference.
  task automatic test_difference_range();
    settle();
    write_reg(pfc_pkg::REG_PROP_GAIN, 32'h0);
    write_reg(pfc_pkg::REG_DERIV_GAIN, I32_MIN);
    send_item(make_item(I32_MIN, I32_MAX, 32'h0));
    send_item(make_item(I32_MAX, I32_MIN, 32'h0));
    send_item(make_item(I32_MIN, I32_MAX, 32'h0));
    settle();
    write_reg(pfc_pkg::REG_DERIV_GAIN, I32_MAX);
    send_item(make_item(I32_MIN, I32_MAX, 32'h0));
  endtask

  task automatic test_integrator_clamp();
    settle();
    write_reg(pfc_pkg::REG_DERIV_GAIN, 32'h0);
    write_reg(pfc_pkg::REG_INT_GAIN_DT, Q_ONE);
    write_reg(pfc_pkg::REG_ACCUM_LIMIT, 32'h8003_0000);  // top bit lies outside the register
    repeat (4) send_item(make_item(32'h0, 32'h0001_8000, 32'h0));
    settle();
    // The accumulator now sits above the new bound and must be pulled back.
    write_reg(pfc_pkg::REG_ACCUM_LIMIT, Q_ONE);
    send_item(make_item(32'h0, 32'h0, 32'h0));
    send_item(make_item(32'h0005_0000, 32'h0, 32'h0));
    settle();
    write_reg(pfc_pkg::REG_ACCUM_LIMIT, 32'hFFFF_FFFF);
    send_item(make_item(I32_MIN, I32_MAX, 32'h0));
    send_item(make_item(I32_MIN, I32_MAX, 32'h0));
  endtask

  task automatic test_feedforward();
    settle();
    write_reg(pfc_pkg::REG_INT_GAIN_DT, 32'h0);
    write_reg(pfc_pkg::REG_FF_GAIN, I32_MIN);
    send_item(make_item(32'h0, 32'h0, I32_MIN));
    send_item(make_item(32'h0, 32'h0, I32_MAX));
    settle();
    write_reg(pfc_pkg::REG_FF_GAIN, I32_MAX);
    send_item(make_item(32'h0, 32'h0, I32_MIN));
  endtask

  task automatic test_drive_range();
    settle();
    write_reg(pfc_pkg::REG_FF_GAIN, 32'h0);
    write_reg(pfc_pkg::REG_PROP_GAIN, Q_ONE);
    write_reg(pfc_pkg::REG_OUT_LOW, 32'hABCD_8000);
    write_reg(pfc_pkg::REG_OUT_HIGH, 32'h1234_7FFF);
    send_item(make_item(I32_MIN, I32_MAX, 32'h0));
    send_item(make_item(I32_MAX, I32_MIN, 32'h0));
    settle();
    // Inverted range: anything not above the high bound lands on the low bound.
    write_reg(pfc_pkg::REG_OUT_LOW, 32'h0000_0064);
    write_reg(pfc_pkg::REG_OUT_HIGH, 32'h0000_FF9C);
    send_item(make_item(32'h0, 32'h00C8_0000, 32'h0));
    send_item(make_item(32'h00C8_0000, 32'h0, 32'h0));
    send_item(make_item(32'h0, 32'h0, 32'h0));
  endtask

  task automatic test_unused_index();
    settle();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_item(make_item(32'h0003_0000, 32'h0, 32'h0));
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      program_random();
      idle_on = (ph != 3);
      send_random(150);
    end
    idle_on = 1'b1;
  endtask

  // The receiver stops for a long stretch while the sender keeps offering items.
  task automatic test_output_backpressure();
    settle();
    idle_on = 1'b0;
    rx_hold_req = 1'b1;
    send_random(40);
    idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    settle();
    program_random();
    send_random(30);
    settle();
    send_random(30);
  endtask

  task automatic test_no_idle();
    settle();
    program_random();
    idle_on = 1'b0;
    send_random(150);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : rx_ready_gen
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    pfc_pkg::pfc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (ctrl_expect_q.size() == 0) begin
        if (n_fail < REPORT_MAX) $error("result transfer with no result expected");
        n_fail++;
      end else begin
        want = ctrl_expect_q.pop_front();
        if (out_data.drive !== want.drive) begin
          if (n_fail < REPORT_MAX)
            $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(out_data.drive));
          n_fail++;
        end
        if (out_data.pid_sum !== want.pid_sum) begin
          if (n_fail < REPORT_MAX)
            $error("pid_sum: expected %0d, got %0d", $signed(want.pid_sum),
                   $signed(out_data.pid_sum));
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_error_saturation();
    test_difference_range();
    test_integrator_clamp();
    test_feedforward();
    test_drive_range();
    test_unused_index();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();
    test_no_idle();
    settle();

    if (ctrl_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", ctrl_expect_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
